@@ hdl/fpadd_pkg.sv @@
package fpadd_pkg;

	localparam int unsigned XBITS = 3;
	localparam int unsigned MW = 24 + XBITS + 1;   // working significand width

	localparam logic [31:0] ABS_MASK = 32'h7fffffff;
	localparam logic [31:0] INF_BITS = 32'h7f800000;
	localparam logic [31:0] NAN_BITS = 32'h7f84ffff;
	localparam logic [7:0]  EXP_MAX  = 8'hff;

	typedef logic [31:0] fp32_t;

	// right shift of a working significand with the lost bits ORed into bit 0
	function automatic logic [MW-1:0] sticky_shr(input logic [MW-1:0] v, input logic [7:0] d);
		logic [MW-1:0] s;
		logic [MW-1:0] lost;
		begin
			if (d >= 8'd31) begin
				s = {{(MW-1){1'b0}}, |v};
			end else begin
				s = v >> d;
				lost = v & ~({MW{1'b1}} << d);
				s[0] = s[0] | (|lost);
			end
			return s;
		end
	endfunction

	// leading zeros of a 27-bit value, counted from bit 26 downward (value known nonzero)
	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       found;
		begin
			n = 5'd0;
			found = 1'b0;
			for (int i = 26; i >= 0; i--) begin
				if (!found && v[i]) begin
					found = 1'b1;
					n = 5'(26 - i);
				end
			end
			return n;
		end
	endfunction

endpackage

@@ hdl/fpadd_core.sv @@
module fpadd_core (
	input  logic [31:0] a_in,
	input  logic [31:0] b_in,
	output logic [31:0] sum
);

	localparam int unsigned MW = fpadd_pkg::MW;

	logic [7:0]    ea, eb, exa, exb;
	logic [31:0]   big, sml;
	logic          nan_a, nan_b, inf_big, inf_sml;
	logic [MW-1:0] ma, mb, m, mn;
	logic [9:0]    e;
	logic [4:0]    lz;
	logic [24:0]   mant;
	logic          rnd;

	always_comb begin
		ea = a_in[30:23];
		eb = b_in[30:23];
		nan_a = (ea == fpadd_pkg::EXP_MAX) && (a_in[22:0] != 23'd0);
		nan_b = (eb == fpadd_pkg::EXP_MAX) && (b_in[22:0] != 23'd0);
		if ((a_in & fpadd_pkg::ABS_MASK) < (b_in & fpadd_pkg::ABS_MASK)) begin
			big = b_in;
			sml = a_in;
		end else begin
			big = a_in;
			sml = b_in;
		end
		exa = big[30:23];
		exb = sml[30:23];
		inf_big = (big & fpadd_pkg::ABS_MASK) == fpadd_pkg::INF_BITS;
		inf_sml = (sml & fpadd_pkg::ABS_MASK) == fpadd_pkg::INF_BITS;

		ma = {1'b0, 1'b1, big[22:0], 3'b000};
		mb = fpadd_pkg::sticky_shr({1'b0, 1'b1, sml[22:0], 3'b000}, exa - exb);
		e = {2'b00, exa};
		lz = 5'd0;
		if (big[31] == sml[31]) begin
			m = ma + mb;
			if (m[MW-1]) begin
				mn = fpadd_pkg::sticky_shr(m, 8'd1);
				e = e + 10'd1;
			end else begin
				mn = m;
			end
		end else begin
			m = ma - mb;
			lz = fpadd_pkg::lzc27(m[26:0]);
			mn = m << lz;
			e = e - {5'd0, lz};
		end
		rnd = mn[2] && ((mn[1:0] != 2'b00) || mn[3]);
		mant = {1'b0, mn[26:3]} + {24'd0, rnd};
		if (mant[24]) begin
			mant = mant >> 1;
			e = e + 10'd1;
		end

		if (ea == 8'd0) begin
			sum = b_in;
		end else if (eb == 8'd0) begin
			sum = a_in;
		end else if (((a_in & fpadd_pkg::ABS_MASK) == (b_in & fpadd_pkg::ABS_MASK))
				&& (a_in[31] != b_in[31]) && !inf_big && !nan_a && !nan_b) begin
			sum = 32'd0;
		end else if (nan_a || nan_b) begin
			// NaN always orders as the larger magnitude unless both are NaN
			sum = fpadd_pkg::NAN_BITS;
		end else if (inf_big) begin
			sum = (inf_sml && (big[31] != sml[31])) ? fpadd_pkg::NAN_BITS : big;
		end else if (!e[9] && (e >= 10'd255)) begin
			sum = {big[31], 31'h7f800000};
		end else if (e[9] || (e == 10'd0)) begin
			sum = 32'd0;
		end else begin
			sum = {big[31], e[7:0], mant[22:0]};
		end
	end

endmodule

@@ hdl/fp32_adder.sv @@
// channel | valid    | stall    | payload
// in      | in_valid | in_stall | operand_a, operand_b
// out     | out_valid| out_stall| sum_bits
// One transaction per cycle while out_stall does not hold it; each passes
// the input register, the single combinational pass and the result register.
// arst_n clears both valid flags.
// out_stall holds a full result register and, when it is full too, the input register.
module fp32_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_bits
);

	logic        v_s1;
	logic [31:0] a_s1, b_s1;
	logic [31:0] sum_c;
	logic        adv_s2, adv_s1;

	assign adv_s2 = !out_valid || !out_stall;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
	end

	fpadd_core u_core (
		.a_in(a_s1),
		.b_in(b_s1),
		.sum (sum_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			sum_bits <= sum_c;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_bits))
		else $error("result changed under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_stall |=> out_valid)
		else $error("stage 1 transaction lost");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("spurious input stall");

endmodule
